// File: design/sbx_pkg.sv
// Shared types and constants for the horizontal Sobel filter on eight-pixel words.
// No dependencies; every other file of the block imports this package.
package sbx_pkg;

    localparam int PIX_PER_WORD = 8;
    localparam int PIX_BITS     = 10;
    localparam int MAX_WORDS    = 256;

    localparam int GRAD_BITS    = 10;
    localparam int GRAD_MAX     = 1023;
    localparam int GSUM_W       = PIX_BITS + 4;

    localparam int ROWS_W       = 12;
    localparam int CNT_W        = 9;
    localparam int ADDR_W       = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 12;

    localparam int OUT_DEPTH    = 4;
    localparam int OUT_PTR_W    = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W    = $clog2(OUT_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_ROWS = 2'd0,
        CFG_ROW_WORDS  = 2'd1
    } cfg_idx_t;

    typedef logic [PIX_BITS-1:0]                       pix_t;
    typedef logic [PIX_PER_WORD-1:0][PIX_BITS-1:0]     word_t;
    typedef logic [2:0][PIX_PER_WORD-1:0][PIX_BITS-1:0] col_t;
    typedef logic [PIX_PER_WORD-1:0][GRAD_BITS-1:0]    grad_word_t;

    typedef struct packed {
        word_t top;
        word_t mid;
    } line_entry_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              c_zero;
        logic              c_one;
        logic              last;
        logic              flush;
        logic              emit;
        logic              top_rep;
    } b_info_t;

    typedef struct packed {
        grad_word_t grad;
        logic       row_end;
        logic       frame_end;
    } res_t;

endpackage

// File: design/sbx_line_buf.sv
// Two-row line store: one entry per word column holds the two older rows.
// Registered read with forwarding of a same-cycle write; uses sbx_pkg.
module sbx_line_buf (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        rd_en,
    input  logic [sbx_pkg::ADDR_W-1:0]  rd_addr,
    input  logic                        wr_en,
    input  logic [sbx_pkg::ADDR_W-1:0]  wr_addr,
    input  sbx_pkg::line_entry_t        wr_data,
    output sbx_pkg::line_entry_t        rd_data
);
    import sbx_pkg::*;

    line_entry_t mem [MAX_WORDS];
    line_entry_t rd_q_reg;
    line_entry_t byp_data_reg;
    logic        byp_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_q_reg     <= mem[rd_addr];
            byp_data_reg <= wr_data;
        end
    end

    // forward the entry written at the same edge as the read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_reg <= 1'b0;
        end else if (rd_en) begin
            byp_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : rd_q_reg;

endmodule

// File: design/sbx_lane.sv
// One gradient lane: horizontal 3x3 Sobel on one pixel, clamped to the output range.
// Uses sbx_pkg.
module sbx_lane (
    input  logic [2:0][sbx_pkg::PIX_BITS-1:0] lft,
    input  logic [2:0][sbx_pkg::PIX_BITS-1:0] rgt,
    output logic [sbx_pkg::GRAD_BITS-1:0]     grad
);
    import sbx_pkg::*;

    logic signed [GSUM_W-1:0] d0, d1, d2, sum;

    assign d0  = $signed(GSUM_W'(rgt[0])) - $signed(GSUM_W'(lft[0]));
    assign d1  = $signed(GSUM_W'(rgt[1])) - $signed(GSUM_W'(lft[1]));
    assign d2  = $signed(GSUM_W'(rgt[2])) - $signed(GSUM_W'(lft[2]));
    assign sum = d0 + (d1 <<< 1) + d2;

    always_comb begin
        if (sum < 0) begin
            grad = '0;
        end else if (sum > $signed(GSUM_W'(GRAD_MAX))) begin
            grad = GRAD_BITS'(GRAD_MAX);
        end else begin
            grad = sum[GRAD_BITS-1:0];
        end
    end

endmodule

// File: design/sbx_grad_word.sv
// Gradient of one word: selects rows and edge columns, then runs one lane per pixel.
// Uses sbx_pkg and sbx_lane.
module sbx_grad_word (
    input  logic                  left_present,
    input  sbx_pkg::col_t         left_col,
    input  sbx_pkg::col_t         mid_col,
    input  logic                  right_present,
    input  sbx_pkg::col_t         right_col,
    input  logic                  top_rep,
    input  logic                  bot_rep,
    output sbx_pkg::grad_word_t   grad
);
    import sbx_pkg::*;

    logic [1:0] srow [3];
    pix_t       ext  [3][PIX_PER_WORD+2];

    assign srow[0] = top_rep ? 2'd1 : 2'd0;
    assign srow[1] = 2'd1;
    assign srow[2] = bot_rep ? 2'd1 : 2'd2;

    // replicate the middle word's own edge pixel where no neighbor word exists
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < PIX_PER_WORD; k++) begin
                ext[r][k+1] = mid_col[srow[r]][k];
            end
            ext[r][0] = left_present ? left_col[srow[r]][PIX_PER_WORD-1]
                                     : mid_col[srow[r]][0];
            ext[r][PIX_PER_WORD+1] = right_present ? right_col[srow[r]][0]
                                                   : mid_col[srow[r]][PIX_PER_WORD-1];
        end
    end

    for (genvar k = 0; k < PIX_PER_WORD; k++) begin : g_lane
        sbx_lane u_lane (
            .lft  ({ext[2][k],   ext[1][k],   ext[0][k]}),
            .rgt  ({ext[2][k+2], ext[1][k+2], ext[0][k+2]}),
            .grad (grad[k])
        );
    end

endmodule

// File: design/sbx_out_fifo.sv
// Result queue: takes up to two items per cycle in order, hands out one per cycle.
// Uses sbx_pkg.
module sbx_out_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_a,
    input  sbx_pkg::res_t  data_a,
    input  logic           push_b,
    input  sbx_pkg::res_t  data_b,
    output logic           room_two,
    output logic           out_valid,
    input  logic           out_ready,
    output sbx_pkg::res_t  out_data
);
    import sbx_pkg::*;

    res_t                 q_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [OUT_CNT_W-1:0] count_reg;
    logic                 pop;
    logic [OUT_PTR_W-1:0] wr_ptr_b;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_data  = q_mem[rd_ptr_reg];
    assign room_two  = (count_reg <= OUT_CNT_W'(OUT_DEPTH - 2));
    assign wr_ptr_b  = wr_ptr_reg + OUT_PTR_W'(1);

    always_ff @(posedge aclk) begin
        if (push_a) begin
            q_mem[wr_ptr_reg] <= data_a;
        end
        if (push_b) begin
            q_mem[wr_ptr_b] <= data_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + OUT_PTR_W'(push_a) + OUT_PTR_W'(push_b);
            rd_ptr_reg <= rd_ptr_reg + OUT_PTR_W'(pop);
            count_reg  <= count_reg + OUT_CNT_W'(push_a) + OUT_CNT_W'(push_b)
                          - OUT_CNT_W'(pop);
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= OUT_CNT_W'(OUT_DEPTH))
        else $error("result queue overfilled");

    a_b_needs_a: assert property (@(posedge aclk) disable iff (!aresetn)
        push_b |-> push_a)
        else $error("second push without first");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push_a |-> count_reg <= OUT_CNT_W'(OUT_DEPTH - 2))
        else $error("push into a queue without room for two");

endmodule

// File: design/sbx_pkg_top_note.sv
// Configuration decode and frame counters of the Sobel filter's input side.
// Uses sbx_pkg; instantiated by sobel_x_filter_8pix_words.
module sbx_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic [sbx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sbx_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          accept,
    input  logic                          cmd,
    output logic                          ignore,
    output sbx_pkg::b_info_t              info
);
    import sbx_pkg::*;

    logic [ROWS_W-1:0] frame_rows_reg, rows_eff;
    logic [CNT_W-1:0]  row_words_reg, width_eff;
    logic [ROWS_W-1:0] row_count_reg, row_count_next;
    logic [CNT_W-1:0]  word_count_reg, word_count_next, c;
    logic              flush, last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_rows_reg <= ROWS_W'(1080);
            row_words_reg  <= CNT_W'(240);
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_FRAME_ROWS: frame_rows_reg <= cfg_data[ROWS_W-1:0];
                CFG_ROW_WORDS:  row_words_reg  <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        rows_eff  = (frame_rows_reg == '0) ? ROWS_W'(1) : frame_rows_reg;
        width_eff = (row_words_reg == '0) ? CNT_W'(1)
                  : ((row_words_reg > CNT_W'(MAX_WORDS)) ? CNT_W'(MAX_WORDS) : row_words_reg);
        c         = (word_count_reg >= CNT_W'(MAX_WORDS)) ? CNT_W'(MAX_WORDS - 1)
                                                          : word_count_reg;
        last      = ({1'b0, c} + (CNT_W+1)'(1)) >= {1'b0, width_eff};
        flush     = (row_count_reg >= rows_eff);
        ignore    = !flush && cmd;

        info.addr    = c[ADDR_W-1:0];
        info.c_zero  = (c == '0);
        info.c_one   = (c == CNT_W'(1));
        info.last    = last;
        info.flush   = flush;
        info.emit    = (row_count_reg != '0);
        info.top_rep = (row_count_reg == ROWS_W'(1));

        if (last) begin
            word_count_next = '0;
            row_count_next  = flush ? '0 : row_count_reg + ROWS_W'(1);
        end else begin
            word_count_next = c + CNT_W'(1);
            row_count_next  = row_count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg  <= '0;
            word_count_reg <= '0;
        end else if (accept && !ignore) begin
            row_count_reg  <= row_count_next;
            word_count_reg <= word_count_next;
        end
    end

endmodule

// File: design/sobel_x_filter_8pix_words.sv
// Horizontal 3x3 Sobel filter over a raster frame carried as words of eight pixels.
// Uses sbx_pkg, sbx_ctrl, sbx_line_buf, sbx_grad_word and sbx_out_fifo.
//
// The block takes one input item per clock while the work stage can advance: each
// word goes into a one-word pipeline stage while the line store is read at its
// column, and the next word is accepted in the following cycle unless that stage
// stalls. A word at the end of a row of two or more words yields two result items
// (the previous word and the row's last word); the result side drains one item per
// cycle while m_ready is high from a four-entry queue, and the input stalls only
// when that queue cannot take two more. A result item goes from the work stage
// register into the queue before the output. The line store holds the two older
// rows per word column in one memory of MAX_WORDS entries, read and rewritten
// once per word; a word in the same column as the one just written (one-word
// rows) is forwarded. Outputs lag one row and one word: the first row is only
// stored, and once frame_rows rows are in, each further item (pixel word or
// flush) produces the bottom row, replicating the last row below it. Top and
// bottom rows and the left and right pixels replicate their nearest neighbor.
// Clamped gradients are 0..1023. The line store needs no clearing after reset.
// Write configuration only while no item is in flight.
module sobel_x_filter_8pix_words (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_cmd,
    input  logic [sbx_pkg::PIX_BITS-1:0]  s_pix_0,
    input  logic [sbx_pkg::PIX_BITS-1:0]  s_pix_1,
    input  logic [sbx_pkg::PIX_BITS-1:0]  s_pix_2,
    input  logic [sbx_pkg::PIX_BITS-1:0]  s_pix_3,
    input  logic [sbx_pkg::PIX_BITS-1:0]  s_pix_4,
    input  logic [sbx_pkg::PIX_BITS-1:0]  s_pix_5,
    input  logic [sbx_pkg::PIX_BITS-1:0]  s_pix_6,
    input  logic [sbx_pkg::PIX_BITS-1:0]  s_pix_7,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sbx_pkg::GRAD_BITS-1:0] m_grad_0,
    output logic [sbx_pkg::GRAD_BITS-1:0] m_grad_1,
    output logic [sbx_pkg::GRAD_BITS-1:0] m_grad_2,
    output logic [sbx_pkg::GRAD_BITS-1:0] m_grad_3,
    output logic [sbx_pkg::GRAD_BITS-1:0] m_grad_4,
    output logic [sbx_pkg::GRAD_BITS-1:0] m_grad_5,
    output logic [sbx_pkg::GRAD_BITS-1:0] m_grad_6,
    output logic [sbx_pkg::GRAD_BITS-1:0] m_grad_7,
    output logic                          m_row_end,
    output logic                          m_frame_end,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sbx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sbx_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sbx_pkg::*;

    logic        accept, ignore;
    b_info_t     a_info;

    logic        b_valid_reg;
    b_info_t     b_info_reg;
    word_t       b_pix_reg;
    logic        b_fire;

    word_t       in_word;
    line_entry_t rd_entry, wr_entry;
    col_t        cur_col;
    col_t        w0_reg, w1_reg;

    grad_word_t  grad_a, grad_b;
    logic        res_a_v, res_b_v;
    res_t        res_a, res_b, push_a_data, head;
    logic        fifo_room;

    assign cfg_ready = 1'b1;

    assign in_word = {s_pix_7, s_pix_6, s_pix_5, s_pix_4,
                      s_pix_3, s_pix_2, s_pix_1, s_pix_0};

    // advance the work stage when the queue has room for both possible results
    assign b_fire  = b_valid_reg && fifo_room;
    assign s_ready = !b_valid_reg || b_fire;
    assign accept  = s_valid && s_ready;

    sbx_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .cmd       (s_cmd),
        .ignore    (ignore),
        .info      (a_info)
    );

    // work stage: an early flush is taken and dropped without entering
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (accept && !ignore) begin
            b_valid_reg <= 1'b1;
        end else if (b_fire) begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && !ignore) begin
            b_info_reg <= a_info;
            b_pix_reg  <= a_info.flush ? '0 : in_word;
        end
    end

    // shift each row up one place in the line store
    assign wr_entry.top = rd_entry.mid;
    assign wr_entry.mid = b_pix_reg;

    sbx_line_buf u_line (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (a_info.addr),
        .wr_en   (b_fire),
        .wr_addr (b_info_reg.addr),
        .wr_data (wr_entry),
        .rd_data (rd_entry)
    );

    assign cur_col = {b_pix_reg, rd_entry.mid, rd_entry.top};

    // hold the two previous word columns of the window
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w0_reg <= '0;
            w1_reg <= '0;
        end else if (b_fire) begin
            w0_reg <= w1_reg;
            w1_reg <= cur_col;
        end
    end

    // previous word, now that its right neighbor is known
    sbx_grad_word u_grad_a (
        .left_present  (!b_info_reg.c_one),
        .left_col      (w0_reg),
        .mid_col       (w1_reg),
        .right_present (1'b1),
        .right_col     (cur_col),
        .top_rep       (b_info_reg.top_rep),
        .bot_rep       (b_info_reg.flush),
        .grad          (grad_a)
    );

    // last word of the row, right edge replicated
    sbx_grad_word u_grad_b (
        .left_present  (!b_info_reg.c_zero),
        .left_col      (w1_reg),
        .mid_col       (cur_col),
        .right_present (1'b0),
        .right_col     (cur_col),
        .top_rep       (b_info_reg.top_rep),
        .bot_rep       (b_info_reg.flush),
        .grad          (grad_b)
    );

    assign res_a_v = b_info_reg.emit && !b_info_reg.c_zero;
    assign res_b_v = b_info_reg.emit && b_info_reg.last;

    assign res_a.grad      = grad_a;
    assign res_a.row_end   = 1'b0;
    assign res_a.frame_end = 1'b0;
    assign res_b.grad      = grad_b;
    assign res_b.row_end   = 1'b1;
    assign res_b.frame_end = b_info_reg.flush;

    assign push_a_data = res_a_v ? res_a : res_b;

    sbx_out_fifo u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_a    (b_fire && (res_a_v || res_b_v)),
        .data_a    (push_a_data),
        .push_b    (b_fire && res_a_v && res_b_v),
        .data_b    (res_b),
        .room_two  (fifo_room),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (head)
    );

    assign m_grad_0    = head.grad[0];
    assign m_grad_1    = head.grad[1];
    assign m_grad_2    = head.grad[2];
    assign m_grad_3    = head.grad[3];
    assign m_grad_4    = head.grad[4];
    assign m_grad_5    = head.grad[5];
    assign m_grad_6    = head.grad[6];
    assign m_grad_7    = head.grad[7];
    assign m_row_end   = head.row_end;
    assign m_frame_end = head.frame_end;

    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !ignore) |=> b_valid_reg)
        else $error("accepted word lost before the work stage");

    a_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && ignore) |=> !b_valid_reg)
        else $error("dropped flush entered the work stage");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && !b_fire) |=> (b_valid_reg && $stable(b_info_reg)
                                      && $stable(b_pix_reg)))
        else $error("stalled work stage changed");

endmodule
